FILE: rtl/core/rsi_pkg.sv
package rsi_pkg;

  // Number format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Datapath widths, all exact for the worst case
  localparam int EW  = WORD_BITS + 1;      // origin minus centre
  localparam int AW  = 2 * WORD_BITS;      // a = d.d, unsigned
  localparam int HW  = 2 * WORD_BITS + 2;  // h = d.e, signed
  localparam int KW  = 2 * WORD_BITS + 4;  // k = e.e - r*r, signed
  localparam int MW  = KW;                 // wide multiplier operand
  localparam int HMW = MW / 2;             // half operand for partial products
  localparam int PW  = 2 * MW;             // wide product
  localparam int QW  = PW + 1;             // discriminant, signed
  localparam int SW  = PW / 2;             // square root width
  localparam int RW  = SW + 3;             // square root remainder
  localparam int NW  = SW + 2;             // -h - s, signed
  localparam int NMW = NW + FRAC_BITS;     // scaled numerator magnitude

  // Configuration register indexes
  localparam logic [1:0] CFG_CENTRE_X = 2'd0;
  localparam logic [1:0] CFG_CENTRE_Y = 2'd1;
  localparam logic [1:0] CFG_CENTRE_Z = 2'd2;
  localparam logic [1:0] CFG_RADIUS   = 2'd3;

  localparam logic [WORD_BITS-2:0] RADIUS_RESET = (WORD_BITS-1)'(1) << FRAC_BITS;

  // Result constants
  localparam logic [WORD_BITS-1:0] MISS_DIST = ~(WORD_BITS'(1) << FRAC_BITS) + 1'b1;
  localparam logic [WORD_BITS-1:0] MAX_POS   = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MIN_NEG   = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [NMW:0]         NEG_LIM   = (NMW+1)'(1) << (WORD_BITS-1);

  // Side data that travels alongside the square root
  typedef struct packed {
    logic          miss;
    logic [HW-1:0] h;
    logic [AW-1:0] a;
  } rsi_side_t;

endpackage

FILE: rtl/core/ray_sphere_intersection.sv
// Ray against sphere, nearer root of the quadratic in Q16.16.
// Pipeline: 6 product stages, 68 square root stages, then 88 division
// and rounding stages.
// Throughput: one ray per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n, synchronous, active low) empties the pipeline and sets the
// centre to the origin and the radius to 1.0.
module ray_sphere_intersection import rsi_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [WORD_BITS-1:0] in_origin_x,
  input  logic signed [WORD_BITS-1:0] in_origin_y,
  input  logic signed [WORD_BITS-1:0] in_origin_z,
  input  logic signed [WORD_BITS-1:0] in_dir_x,
  input  logic signed [WORD_BITS-1:0] in_dir_y,
  input  logic signed [WORD_BITS-1:0] in_dir_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic signed [WORD_BITS-1:0] out_distance,
  output logic                        out_saturated,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic        [1:0]           cfg_index,
  input  logic        [WORD_BITS-1:0] cfg_data
);

  logic signed [WORD_BITS-1:0] centre_x_r, centre_y_r, centre_z_r;
  logic        [WORD_BITS-2:0] radius_r;
  logic                        en;
  logic                        fv, sv;
  logic [PW-1:0]               q;
  rsi_side_t                   fside, sside;
  logic [SW-1:0]               root;
  logic [WORD_BITS-1:0]        near_dist;

  // Advance the pipeline unless a result waits untaken; take nothing in reset
  assign en        = !out_valid || out_ready;
  assign in_ready  = rst_n && en;
  assign cfg_ready = rst_n;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r <= '0;
      centre_y_r <= '0;
      centre_z_r <= '0;
      radius_r   <= RADIUS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CENTRE_X: centre_x_r <= cfg_data;
        CFG_CENTRE_Y: centre_y_r <= cfg_data;
        CFG_CENTRE_Z: centre_z_r <= cfg_data;
        CFG_RADIUS:   radius_r   <= cfg_data[WORD_BITS-2:0];
        default:      ;
      endcase
    end
  end

  rsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (in_valid),
    .origin_x (in_origin_x),
    .origin_y (in_origin_y),
    .origin_z (in_origin_z),
    .dir_x    (in_dir_x),
    .dir_y    (in_dir_y),
    .dir_z    (in_dir_z),
    .centre_x (centre_x_r),
    .centre_y (centre_y_r),
    .centre_z (centre_z_r),
    .radius   (radius_r),
    .v_out    (fv),
    .q_out    (q),
    .side_out (fside)
  );

  rsi_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (fv),
    .n_in     (q),
    .side_in  (fside),
    .v_out    (sv),
    .root_out (root),
    .side_out (sside)
  );

  rsi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .v_in      (sv),
    .root_in   (root),
    .side_in   (sside),
    .v_out     (out_valid),
    .hit       (out_hit),
    .distance  (near_dist),
    .saturated (out_saturated)
  );

  assign out_distance = $signed(near_dist);

endmodule

FILE: rtl/core/rsi_mul.sv
module rsi_mul import rsi_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [MW-1:0] x,
  input  logic [MW-1:0] y,
  output logic [PW-1:0] p
);

  logic [2*HMW-1:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [PW-1:0]    p_r;

  // Form the four partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= x[HMW-1:0]  * y[HMW-1:0];
      pp01_r <= x[HMW-1:0]  * y[MW-1:HMW];
      pp10_r <= x[MW-1:HMW] * y[HMW-1:0];
      pp11_r <= x[MW-1:HMW] * y[MW-1:HMW];
    end
  end

  // Sum them at their weights
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= PW'(pp00_r) + (PW'(pp01_r) << HMW) + (PW'(pp10_r) << HMW)
             + (PW'(pp11_r) << MW);
    end
  end

  assign p = p_r;

endmodule

FILE: rtl/core/rsi_front.sv
module rsi_front import rsi_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        v_in,
  input  logic signed [WORD_BITS-1:0] origin_x,
  input  logic signed [WORD_BITS-1:0] origin_y,
  input  logic signed [WORD_BITS-1:0] origin_z,
  input  logic signed [WORD_BITS-1:0] dir_x,
  input  logic signed [WORD_BITS-1:0] dir_y,
  input  logic signed [WORD_BITS-1:0] dir_z,
  input  logic signed [WORD_BITS-1:0] centre_x,
  input  logic signed [WORD_BITS-1:0] centre_y,
  input  logic signed [WORD_BITS-1:0] centre_z,
  input  logic        [WORD_BITS-2:0] radius,
  output logic                        v_out,
  output logic        [PW-1:0]        q_out,
  output rsi_side_t                   side_out
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  logic signed [WORD_BITS-1:0] d_r [3];
  logic signed [EW-1:0]        e_r [3];
  logic [AW-1:0]               dd_r [3];
  logic signed [WORD_BITS+EW-1:0] de_r [3];
  logic [2*EW-1:0]             ee_r [3];
  logic [2*WORD_BITS-3:0]      rr_r;
  logic [AW-1:0]               a_r;
  logic [HW-1:0]               h_r;
  logic [KW-1:0]               k_r;
  logic [HW-1:0]               habs;
  logic [KW-1:0]               kabs;
  logic [PW-1:0]               hh, ak;
  logic [AW-1:0]               a4_r, a5_r;
  logic [HW-1:0]               h4_r, h5_r;
  logic                        kneg4_r, kneg5_r;
  logic [QW-1:0]               q_nxt;
  logic [QW-1:0]               q_r;
  rsi_side_t                   side_r;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Capture direction and offset from the centre
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= dir_x;
      d_r[1] <= dir_y;
      d_r[2] <= dir_z;
      e_r[0] <= EW'(origin_x) - EW'(centre_x);
      e_r[1] <= EW'(origin_y) - EW'(centre_y);
      e_r[2] <= EW'(origin_z) - EW'(centre_z);
    end
  end

  // Per-axis products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd_r[i] <= d_r[i] * d_r[i];
        de_r[i] <= d_r[i] * e_r[i];
        ee_r[i] <= e_r[i] * e_r[i];
      end
      rr_r <= radius * radius;
    end
  end

  // Dot product sums
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= dd_r[0] + dd_r[1] + dd_r[2];
      h_r <= HW'(de_r[0]) + HW'(de_r[1]) + HW'(de_r[2]);
      k_r <= KW'(ee_r[0]) + KW'(ee_r[1]) + KW'(ee_r[2]) - KW'(rr_r);
    end
  end

  assign habs = h_r[HW-1] ? (~h_r + 1'b1) : h_r;
  assign kabs = k_r[KW-1] ? (~k_r + 1'b1) : k_r;

  rsi_mul u_mul_hh (
    .clk (clk),
    .en  (en),
    .x   (MW'(habs)),
    .y   (MW'(habs)),
    .p   (hh)
  );

  rsi_mul u_mul_ak (
    .clk (clk),
    .en  (en),
    .x   (MW'(a_r)),
    .y   (kabs),
    .p   (ak)
  );

  // Hold side data across the multiplier stages
  always_ff @(posedge clk) begin
    if (en) begin
      a4_r    <= a_r;
      h4_r    <= h_r;
      kneg4_r <= k_r[KW-1];
      a5_r    <= a4_r;
      h5_r    <= h4_r;
      kneg5_r <= kneg4_r;
    end
  end

  // Discriminant over four
  assign q_nxt = kneg5_r ? ({1'b0, hh} + {1'b0, ak}) : ({1'b0, hh} - {1'b0, ak});

  always_ff @(posedge clk) begin
    if (en) begin
      q_r         <= q_nxt;
      side_r.miss <= (a5_r == '0) || q_nxt[QW-1];
      side_r.h    <= h5_r;
      side_r.a    <= a5_r;
    end
  end

  assign v_out    = v6_r;
  assign q_out    = q_r[PW-1:0];
  assign side_out = side_r;

endmodule

FILE: rtl/core/rsi_sqrt.sv
module rsi_sqrt import rsi_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic [PW-1:0] n_in,
  input  rsi_side_t     side_in,
  output logic          v_out,
  output logic [SW-1:0] root_out,
  output rsi_side_t     side_out
);

  logic            v_w    [SW+1];
  logic [RW-1:0]   rem_w  [SW+1];
  logic [SW-1:0]   root_w [SW+1];
  logic [PW-1:0]   n_w    [SW+1];
  rsi_side_t       side_w [SW+1];

  assign v_w[0]    = v_in;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign n_w[0]    = n_in;
  assign side_w[0] = side_in;

  // One root bit per stage
  for (genvar j = 0; j < SW; j++) begin : g_stage
    logic            v_r;
    logic [RW-1:0]   rem_r;
    logic [SW-1:0]   root_r;
    logic [PW-1:0]   n_r;
    rsi_side_t       side_r;
    logic [RW-1:0]   rem_sh;
    logic [RW-1:0]   trial;
    logic            ge;

    assign rem_sh = {rem_w[j][RW-3:0], n_w[j][PW-1 -: 2]};
    assign trial  = RW'({root_w[j], 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_w[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= ge ? (rem_sh - trial) : rem_sh;
        root_r <= {root_w[j][SW-2:0], ge};
        n_r    <= {n_w[j][PW-3:0], 2'b00};
        side_r <= side_w[j];
      end
    end

    assign v_w[j+1]    = v_r;
    assign rem_w[j+1]  = rem_r;
    assign root_w[j+1] = root_r;
    assign n_w[j+1]    = n_r;
    assign side_w[j+1] = side_r;
  end

  assign v_out    = v_w[SW];
  assign root_out = root_w[SW];
  assign side_out = side_w[SW];

endmodule

FILE: rtl/core/rsi_div.sv
module rsi_div import rsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 v_in,
  input  logic [SW-1:0]        root_in,
  input  rsi_side_t            side_in,
  output logic                 v_out,
  output logic                 hit,
  output logic [WORD_BITS-1:0] distance,
  output logic                 saturated
);

  logic signed [NW-1:0] hx, sx, nsum;
  logic [NW-1:0]        nmag;
  logic                 v0_r, miss0_r, neg0_r;
  logic [NMW-1:0]       nq0_r;
  logic [AW-1:0]        a0_r;

  logic            v_w    [NMW+1];
  logic            miss_w [NMW+1];
  logic            neg_w  [NMW+1];
  logic [AW-1:0]   a_w    [NMW+1];
  logic [AW-1:0]   r_w    [NMW+1];
  logic [NMW-1:0]  nq_w   [NMW+1];

  logic [NMW-1:0]       q;
  logic [NMW:0]         mag2;
  logic                 v_r, hit_r, sat_r;
  logic [WORD_BITS-1:0] dist_r;
  logic                 hit_nxt, sat_nxt;
  logic [WORD_BITS-1:0] dist_nxt;

  // Numerator -h - s as sign and scaled magnitude
  assign hx   = NW'($signed(side_in.h));
  assign sx   = $signed(NW'(root_in));
  assign nsum = -hx - sx;
  assign nmag = nsum[NW-1] ? (~nsum + 1'b1) : nsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss0_r <= side_in.miss;
      neg0_r  <= nsum[NW-1];
      nq0_r   <= {nmag, {FRAC_BITS{1'b0}}};
      a0_r    <= side_in.a;
    end
  end

  assign v_w[0]    = v0_r;
  assign miss_w[0] = miss0_r;
  assign neg_w[0]  = neg0_r;
  assign a_w[0]    = a0_r;
  assign r_w[0]    = '0;
  assign nq_w[0]   = nq0_r;

  // Restoring division, one quotient bit per stage
  for (genvar j = 0; j < NMW; j++) begin : g_stage
    logic            v_r;
    logic            miss_r, neg_r;
    logic [AW-1:0]   a_r, r_r;
    logic [NMW-1:0]  nq_r;
    logic [AW:0]     t;
    logic            ge;

    assign t  = {r_w[j], nq_w[j][NMW-1]};
    assign ge = t >= {1'b0, a_w[j]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_w[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        miss_r <= miss_w[j];
        neg_r  <= neg_w[j];
        a_r    <= a_w[j];
        r_r    <= ge ? AW'(t - {1'b0, a_w[j]}) : AW'(t);
        nq_r   <= {nq_w[j][NMW-2:0], ge};
      end
    end

    assign v_w[j+1]    = v_r;
    assign miss_w[j+1] = miss_r;
    assign neg_w[j+1]  = neg_r;
    assign a_w[j+1]    = a_r;
    assign r_w[j+1]    = r_r;
    assign nq_w[j+1]   = nq_r;
  end

  // Round toward minus infinity, then clamp; a miss gives MISS_DIST
  assign q    = nq_w[NMW];
  assign mag2 = (NMW+1)'(q) + (NMW+1)'(r_w[NMW] != '0);

  always_comb begin
    hit_nxt  = 1'b1;
    sat_nxt  = 1'b0;
    dist_nxt = q[WORD_BITS-1:0];
    if (miss_w[NMW]) begin
      hit_nxt  = 1'b0;
      dist_nxt = MISS_DIST;
    end else if (neg_w[NMW]) begin
      if (mag2 > NEG_LIM) begin
        sat_nxt  = 1'b1;
        dist_nxt = MIN_NEG;
      end else begin
        dist_nxt = ~mag2[WORD_BITS-1:0] + 1'b1;
      end
    end else if (q[NMW-1:WORD_BITS-1] != '0) begin
      sat_nxt  = 1'b1;
      dist_nxt = MAX_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_w[NMW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_nxt;
      sat_r  <= sat_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign v_out     = v_r;
  assign hit       = hit_r;
  assign distance  = dist_r;
  assign saturated = sat_r;

endmodule

FILE: test/ray_sphere_intersection_test.sv
module ray_sphere_intersection_test import rsi_pkg::*;;

  typedef struct {
    logic [2:0][WORD_BITS-1:0] org;
    logic [2:0][WORD_BITS-1:0] dir;
  } ray_t;

  typedef struct {
    logic                 hit;
    logic [WORD_BITS-1:0] distance;
    logic                 saturated;
  } hit_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [WORD_BITS-1:0] in_origin_x = '0;
  logic signed [WORD_BITS-1:0] in_origin_y = '0;
  logic signed [WORD_BITS-1:0] in_origin_z = '0;
  logic signed [WORD_BITS-1:0] in_dir_x = '0;
  logic signed [WORD_BITS-1:0] in_dir_y = '0;
  logic signed [WORD_BITS-1:0] in_dir_z = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_hit;
  logic signed [WORD_BITS-1:0] out_distance;
  logic                        out_saturated;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [1:0]                  cfg_index = '0;
  logic [WORD_BITS-1:0]        cfg_data = '0;

  // Sphere as the block should hold it
  logic [2:0][WORD_BITS-1:0] sphere_centre;
  logic [WORD_BITS-2:0]      sphere_radius;

  hit_t pending_hits[$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  ray_sphere_intersection dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [255:0] widen(logic [WORD_BITS-1:0] x);
    return {{(256-WORD_BITS){x[WORD_BITS-1]}}, x};
  endfunction

  function automatic logic [255:0] floor_sqrt(logic [255:0] v);
    logic [255:0] r, t;
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      t = r | (256'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Nearer root of the ray/sphere quadratic, exact in 256-bit integers
  function automatic hit_t trace_ray(ray_t ray);
    logic signed [255:0] d, e, a, h, k, q, s, num, t_near, rr;
    logic [255:0]        mag, quo, den;
    hit_t                res;
    a = '0;
    h = '0;
    k = '0;
    for (int i = 0; i < 3; i++) begin
      d = widen(ray.dir[i]);
      e = widen(ray.org[i]) - widen(sphere_centre[i]);
      a = a + d * d;
      h = h + d * e;
      k = k + e * e;
    end
    rr = {225'b0, sphere_radius};
    k = k - rr * rr;
    q = h * h - a * k;
    if (a == 0 || q < 0) begin
      res.hit = 1'b0;
      res.distance = MISS_DIST;
      res.saturated = 1'b0;
      return res;
    end
    s = floor_sqrt(q);
    num = (-h - s) <<< FRAC_BITS;
    den = a;
    // round toward minus infinity
    if (num < 0) begin
      mag = -num;
      quo = mag / den;
      if (mag % den != 0) quo = quo + 1;
      t_near = -quo;
    end else begin
      mag = num;
      t_near = mag / den;
    end
    res.hit = 1'b1;
    res.saturated = 1'b0;
    if (t_near > 256'sd2147483647) begin
      t_near = 256'sd2147483647;
      res.saturated = 1'b1;
    end else if (t_near < -256'sd2147483648) begin
      t_near = -256'sd2147483648;
      res.saturated = 1'b1;
    end
    res.distance = t_near[WORD_BITS-1:0];
    return res;
  endfunction

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result hit=%0b dist=%h sat=%0b",
                   out_hit, out_distance, out_saturated);
      end else begin
        want = pending_hits.pop_front();
        if (out_hit !== want.hit || out_distance !== want.distance ||
            out_saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0b dist=%h sat=%0b, got hit=%0b dist=%h sat=%0b",
                     want.hit, want.distance, want.saturated,
                     out_hit, out_distance, out_saturated);
        end
      end
    end
  end

  task automatic send_ray(ray_t ray);
    // hold off at random, then present the ray until it is taken
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_origin_x <= ray.org[0];
    in_origin_y <= ray.org[1];
    in_origin_z <= ray.org[2];
    in_dir_x <= ray.dir[0];
    in_dir_y <= ray.dir[1];
    in_dir_z <= ray.dir[2];
    do @(posedge clk); while (!in_ready);
    pending_hits.insert(pending_hits.size(), trace_ray(ray));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [WORD_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CENTRE_X: sphere_centre[0] = val;
      CFG_CENTRE_Y: sphere_centre[1] = val;
      CFG_CENTRE_Z: sphere_centre[2] = val;
      CFG_RADIUS:   sphere_radius = val[WORD_BITS-2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_sphere(logic [WORD_BITS-1:0] cx, logic [WORD_BITS-1:0] cy,
                            logic [WORD_BITS-1:0] cz, logic [WORD_BITS-1:0] r);
    drain();
    write_reg(CFG_CENTRE_X, cx);
    write_reg(CFG_CENTRE_Y, cy);
    write_reg(CFG_CENTRE_Z, cz);
    write_reg(CFG_RADIUS, r);
  endtask

  function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_t r;
    r.org[0] = ox;
    r.org[1] = oy;
    r.org[2] = oz;
    r.dir[0] = dx;
    r.dir[1] = dy;
    r.dir[2] = dz;
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] spread(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // Mostly rays aimed near the sphere, with noise, tiny and zero directions
  function automatic ray_t random_ray();
    ray_t r;
    int   mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0, 1: begin
          r.org[i] = $urandom();
          r.dir[i] = $urandom();
        end
        8: begin
          r.org[i] = sphere_centre[i] + spread(32'h0100_0000);
          r.dir[i] = spread(3);
        end
        9: begin
          r.org[i] = sphere_centre[i] + spread(32'h000a_0000);
          r.dir[i] = ($urandom_range(1) != 0) ? '0 : $urandom();
        end
        default: begin
          r.org[i] = sphere_centre[i] + spread(32'h000a_0000);
          r.dir[i] = spread(32'h0004_0000);
        end
      endcase
    end
    return r;
  endfunction

  task automatic test_directed;
    send_ray(make_ray(-5 << 16, 0, 0, 1 << 16, 0, 0));
    send_ray(make_ray(-5 << 16, 2 << 16, 0, 1 << 16, 0, 0));
    send_ray(make_ray(-5 << 16, 1 << 16, 0, 1 << 16, 0, 0));
    send_ray(make_ray(-5 << 16, 0, 0, 0, 0, 0));
    send_ray(make_ray(0, 0, 0, 0, 0, 1 << 16));
    send_ray(make_ray(3 << 16, 0, 0, -(1 << 16), 0, 0));
    send_ray(make_ray(0, 0, 32'h7fff_0000, 0, 0, 1));
    send_ray(make_ray(0, 0, 32'h8000_0000, 0, 0, 1));
    send_ray(make_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_ray(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_ray(make_ray(-1, -1, -1, -1, -1, -1));
    send_ray(make_ray(-(2 << 16), 0, 0, 1, 0, 0));
    send_ray(make_ray(0, 0, 0, 32'h7fff_ffff, 0, 0));
  endtask

  task automatic test_extreme_spheres;
    set_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_ray(make_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                      32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_ray(make_ray(0, 0, 0, 1, 1, 1));
    set_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_ray(make_ray(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                      32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    set_sphere(0, 0, 0, 0);
    send_ray(make_ray(-(4 << 16), 0, 0, 1 << 16, 0, 0));
    send_ray(make_ray(-(4 << 16), 1, 0, 1 << 16, 0, 0));
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    set_sphere(spread(32'h0100_0000), spread(32'h0100_0000), spread(32'h0100_0000),
               $urandom_range(32'h0008_0000));
    for (int i = 0; i < n; i++) begin
      if (i == n / 2)
        set_sphere($urandom(), $urandom(), $urandom(), $urandom());
      send_ray(random_ray());
    end
  endtask

  initial begin
    sphere_centre = '0;
    sphere_radius = RADIUS_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_extreme_spheres();
    test_random(360, 0, 0);
    test_random(360, 67, 0);
    test_random(360, 0, 67);
    test_random(360, 18, 18);
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("ray_sphere_intersection verification clean");
    end else begin
      $display("ray_sphere_intersection verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("ray_sphere_intersection verification failed");
    $finish;
  end

endmodule
